// File: sv/nla_pkg.sv
// ----------------------------------------------------------------------------
// nla_pkg : shared types and constants for the landmark association core
// Widths of the coordinate, id and gate fields, table size, function codes
// and the structs passed between the cell row, the scan unit and the top.
// ----------------------------------------------------------------------------
package nla_pkg;

    // table size and derived counter widths
    localparam int MAX_LANDMARKS = 64;
    localparam int CNT_W         = $clog2(MAX_LANDMARKS + 1);
    localparam int IDX_W         = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int COORD_W = 24;
    localparam int ID_W    = 16;
    localparam int GATE_W  = 23;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;

    localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(12800);

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    // one landmark as held in a cell
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ID_W-1:0]           id;
    } t_entry;

    // per-cycle control from the sequencer to the scan unit
    typedef struct packed {
        logic load;   // new query: latch position, id and gate
        logic vld;    // head entry lies inside the filled part of the table
        logic last;   // final rotation step of this query
    } t_scan_ctl;

endpackage

// File: sv/nearest_landmark_association_core.sv
// ----------------------------------------------------------------------------
// nearest_landmark_association_core : nearest-neighbour landmark matcher
// Landmark table as a row of shifting cells, rotated once per query through
// a three-stage squared-distance pipeline.
// ----------------------------------------------------------------------------
// Clear and append words complete in the cycle they are taken and give no
// result; busy stays low. A query word raises busy while the cell row
// rotates one full turn, one entry per cycle into the distance pipeline,
// and while the pipeline then drains; the result word shows on o_strobe in
// the last busy cycle. The result cannot be held off, so it must be taken
// in the cycle o_strobe is high. The gate radius may be written at any time
// the core is not busy.
// ----------------------------------------------------------------------------
module nearest_landmark_association_core
    import nla_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic [ID_W-1:0]           i_ident,
    input  logic                      i_cfg_we,
    input  logic [GATE_W-1:0]         i_cfg_wdata,
    output logic                      o_strobe,
    output logic [ID_W-1:0]           o_match_id,
    output logic                      o_matched
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_skip;
    logic [IDX_W-1:0]  r_step;
    logic [GATE_W-1:0] r_gate;

    logic      w_accept;
    logic      w_append;
    logic      w_query;
    logic      w_shift;
    logic      w_done;
    t_entry    w_new;
    t_entry    w_head;
    t_entry    w_cell [MAX_LANDMARKS];
    t_entry    w_cell_in [MAX_LANDMARKS];
    t_scan_ctl w_ctl;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    // function decode
    always_comb begin
        w_append = 1'b0;
        w_query  = 1'b0;
        n_count  = r_count;
        if (w_accept) begin
            unique case (i_func)
                FUNC_CLEAR: begin
                    n_count = '0;
                end
                FUNC_APPEND: begin
                    if (r_count < CNT_W'(MAX_LANDMARKS)) begin
                        w_append = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                FUNC_QUERY: begin
                    w_query = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // cell row: append shifts in at slot 0, query rotates last slot to 0
    assign w_new   = '{x: i_pos_x, y: i_pos_y, id: i_ident};
    assign w_head  = w_cell[MAX_LANDMARKS-1];
    assign w_shift = w_append || (r_state == ST_SCAN);

    genvar g;
    generate
        for (g = 0; g < MAX_LANDMARKS; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_cell_in[g] = (r_state == ST_SCAN) ? w_head : w_new;
            end else begin : g_rest
                assign w_cell_in[g] = w_cell[g-1];
            end
            nla_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_cell_in[g]),
                .o_entry (w_cell[g])
            );
        end
    endgenerate

    // oldest entry reaches the head after MAX_LANDMARKS - count steps
    assign w_ctl.load = w_query;
    assign w_ctl.vld  = (r_state == ST_SCAN) && (CNT_W'(r_step) >= r_skip);
    assign w_ctl.last = (r_state == ST_SCAN) && (r_step == IDX_W'(MAX_LANDMARKS - 1));

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_query) n_state = ST_SCAN;
            ST_SCAN: if (w_ctl.last) n_state = ST_WAIT;
            ST_WAIT: if (w_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_gate  <= GATE_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_query) begin
                r_step <= '0;
            end else if (r_state == ST_SCAN) begin
                r_step <= r_step + IDX_W'(1);
            end
            if (i_cfg_we) begin
                r_gate <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_skip <= CNT_W'(MAX_LANDMARKS) - r_count;
        end
    end

    nla_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_entry    (w_head),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_ident    (i_ident),
        .i_gate     (r_gate),
        .o_done     (w_done),
        .o_match_id (o_match_id),
        .o_matched  (o_matched)
    );

    assign o_strobe = w_done;

endmodule

// File: sv/nla_cell.sv
// ----------------------------------------------------------------------------
// nla_cell : one landmark slot of the cell row
// Holds one table entry and takes its neighbour's entry whenever the row
// shifts (append or rotation during a query).
// ----------------------------------------------------------------------------
module nla_cell
    import nla_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    // slot register, payload only
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: sv/nla_scan.sv
// ----------------------------------------------------------------------------
// nla_scan : distance pipeline and best-match tracker
// Stage 1 forms the coordinate differences, stage 2 squares them, stage 3
// sums and compares against the running best (initially gate squared).
// ----------------------------------------------------------------------------
module nla_scan
    import nla_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_scan_ctl                 i_ctl,
    input  t_entry                    i_entry,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic [ID_W-1:0]           i_ident,
    input  logic [GATE_W-1:0]         i_gate,
    output logic                      o_done,
    output logic [ID_W-1:0]           o_match_id,
    output logic                      o_matched
);

    // query latch
    logic signed [COORD_W-1:0] r_qx;
    logic signed [COORD_W-1:0] r_qy;

    // stage 1
    logic                     r_s1_vld;
    logic                     r_s1_last;
    logic signed [DIFF_W-1:0] r_s1_dx;
    logic signed [DIFF_W-1:0] r_s1_dy;
    logic [ID_W-1:0]          r_s1_id;

    // stage 2
    logic              r_s2_vld;
    logic              r_s2_last;
    logic [SQ_W-1:0]   r_s2_sqx;
    logic [SQ_W-1:0]   r_s2_sqy;
    logic [ID_W-1:0]   r_s2_id;

    // running best
    logic [DIST_W-1:0] r_best;
    logic [ID_W-1:0]   r_bid;
    logic              r_hit;

    // result
    logic              r_res_vld;
    logic [ID_W-1:0]   r_res_id;
    logic              r_res_hit;

    logic signed [2*DIFF_W-1:0] w_px;
    logic signed [2*DIFF_W-1:0] w_py;
    logic [2*GATE_W-1:0]        w_gsq;
    logic [DIST_W-1:0]          w_sum;
    logic                       w_take;
    logic [ID_W-1:0]            n_bid;
    logic                       n_hit;

    assign w_px  = r_s1_dx * r_s1_dx;
    assign w_py  = r_s1_dy * r_s1_dy;
    assign w_gsq = i_gate * i_gate;

    // stage 3: strict compare keeps the earliest of equal distances
    assign w_sum  = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
    assign w_take = r_s2_vld && (w_sum < r_best);
    assign n_bid  = w_take ? r_s2_id : r_bid;
    assign n_hit  = w_take | r_hit;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_ctl.vld;
            r_s1_last <= i_ctl.last;
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;
            r_res_vld <= r_s2_last;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_s1_dx  <= DIFF_W'(r_qx) - DIFF_W'(i_entry.x);
        r_s1_dy  <= DIFF_W'(r_qy) - DIFF_W'(i_entry.y);
        r_s1_id  <= i_entry.id;
        r_s2_sqx <= w_px[SQ_W-1:0];
        r_s2_sqy <= w_py[SQ_W-1:0];
        r_s2_id  <= r_s1_id;
        if (i_ctl.load) begin
            r_qx   <= i_pos_x;
            r_qy   <= i_pos_y;
            r_best <= DIST_W'(w_gsq);
            r_bid  <= i_ident;
            r_hit  <= 1'b0;
        end else if (w_take) begin
            r_best <= w_sum;
            r_bid  <= n_bid;
            r_hit  <= n_hit;
        end
        if (r_s2_last) begin
            r_res_id  <= n_bid;
            r_res_hit <= n_hit;
        end
    end

    assign o_done     = r_res_vld;
    assign o_match_id = r_res_id;
    assign o_matched  = r_res_hit;

endmodule

// File: sv/nla_checker.sv
// ----------------------------------------------------------------------------
// nla_checker : port-level checks for the landmark association core
// Watches start/busy against the result strobe over time.
// ----------------------------------------------------------------------------
module nla_checker
    import nla_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [FUNC_W-1:0] i_func,
    input logic              o_strobe
);

    // a result word only closes a query in progress
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result word outside a query");

    // a query holds the core busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_QUERY) |=> busy)
        else $error("query taken without busy");

    // clear and append never make the core busy
    a_table_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func != FUNC_QUERY) |=> !busy)
        else $error("table word made the core busy");

    // busy drops right after the result word
    a_strobe_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!busy && !o_strobe))
        else $error("core still busy after result word");

endmodule

bind nearest_landmark_association_core nla_checker u_nla_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_func   (i_func),
    .o_strobe (o_strobe)
);

// File: tb/tb_nearest_landmark_association_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_landmark_association_core : self-checking bench for the matcher
// A queue of table and query words, filled up front, feeds a clocked driver.
// An in-bench model of the landmark table predicts every query result, and a
// clocked monitor checks each strobed result word against the oldest
// prediction. The gate radius is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_nearest_landmark_association_core;
    import nla_pkg::*;

    localparam int                       RANDOM_WORDS = 780;
    localparam int                       SETTLE       = 8;      // quiet cycles before a gate write
    localparam int                       DRAIN        = 100;    // tail after the last result
    localparam int                       LIMIT        = 600000; // cycle budget for the whole run
    localparam logic [FUNC_W-1:0]        FUNC_UNUSED  = 2'd3;
    localparam logic signed [COORD_W-1:0] C_MAX       = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN       = 24'sh800000;
    localparam logic [GATE_W-1:0]        GATE_MAX     = {GATE_W{1'b1}};

    typedef enum logic {WORD_ITEM, WORD_GATE} t_word_kind;

    // one pending word: a table or query word, or a gate radius write
    typedef struct {
        t_word_kind                kind;
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ID_W-1:0]           ident;
        logic [GATE_W-1:0]         gate;
    } t_word;

    // predicted association for one query
    typedef struct {
        logic [ID_W-1:0] id;
        logic            matched;
    } t_assoc;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [FUNC_W-1:0]         func = '0;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic [ID_W-1:0]           ident = '0;
    logic                      cfg_we = 1'b0;
    logic [GATE_W-1:0]         cfg_wdata = '0;
    logic                      o_strobe;
    logic [ID_W-1:0]           o_match_id;
    logic                      o_matched;

    t_word  word_q[$];
    t_assoc assoc_due_q[$];

    // model state
    t_entry          landmark_mem [MAX_LANDMARKS];
    int              landmark_cnt = 0;
    logic [GATE_W-1:0] gate_model = GATE_RESET;

    int err_cnt         = 0;
    int words_taken     = 0;
    int queries_checked = 0;
    int hits_predicted  = 0;
    int appends_dropped = 0;
    int gates_written   = 0;
    int cycle_cnt       = 0;

    nearest_landmark_association_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (func),
        .i_pos_x     (pos_x),
        .i_pos_y     (pos_y),
        .i_ident     (ident),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_strobe    (o_strobe),
        .o_match_id  (o_match_id),
        .o_matched   (o_matched)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // table model: clear, append, nearest gated landmark search
    task automatic associate_word(input t_word w);
        longint dx;
        longint dy;
        longint d2;
        longint best;
        t_assoc res;
        case (w.func)
            FUNC_CLEAR: landmark_cnt = 0;
            FUNC_APPEND: begin
                if (landmark_cnt < MAX_LANDMARKS) begin
                    landmark_mem[landmark_cnt] = '{x: w.x, y: w.y, id: w.ident};
                    landmark_cnt++;
                end else begin
                    appends_dropped++;
                end
            end
            FUNC_QUERY: begin
                best        = longint'(gate_model) * longint'(gate_model);
                res.id      = w.ident;
                res.matched = 1'b0;
                // strict less-than keeps the earliest of equal distances
                for (int i = 0; i < landmark_cnt; i++) begin
                    dx = longint'(w.x) - longint'(landmark_mem[i].x);
                    dy = longint'(w.y) - longint'(landmark_mem[i].y);
                    d2 = dx * dx + dy * dy;
                    if (d2 < best) begin
                        best        = d2;
                        res.id      = landmark_mem[i].id;
                        res.matched = 1'b1;
                    end
                end
                if (res.matched)
                    hits_predicted++;
                assoc_due_q = {assoc_due_q, res};
            end
            default: ; // unused code, ignored
        endcase
    endtask

    // driver: presents words, holds them while busy, writes the gate when quiet
    always @(posedge i_clk) begin : drive
        logic  go;
        logic  we;
        int    idle_run;
        t_word w;
        if (!i_rst_n) begin
            start    <= 1'b0;
            cfg_we   <= 1'b0;
            idle_run = 0;
        end else begin
            if (start && !busy) begin
                w = word_q.pop_front();
                associate_word(w);
                words_taken++;
            end
            if (cfg_we) begin
                w = word_q.pop_front();
                gate_model = cfg_wdata;
                gates_written++;
            end
            if (!busy && !start && !cfg_we)
                idle_run++;
            else
                idle_run = 0;
            // a word not yet taken stays on the port unchanged
            if (!(start && busy)) begin
                go = 1'b0;
                we = 1'b0;
                if (word_q.size() > 0) begin
                    if (word_q[0].kind == WORD_GATE) begin
                        if (!cfg_we && idle_run >= SETTLE && assoc_due_q.size() == 0)
                            we = 1'b1;
                    end else if ((words_taken >= 300 && words_taken < 420) ||
                                 $urandom_range(0, 99) >= 31) begin
                        go = 1'b1;
                    end
                end
                start  <= go;
                cfg_we <= we;
                if (go) begin
                    func  <= word_q[0].func;
                    pos_x <= word_q[0].x;
                    pos_y <= word_q[0].y;
                    ident <= word_q[0].ident;
                end
                if (we)
                    cfg_wdata <= word_q[0].gate;
            end
        end
    end

    // monitor: every strobed result word against the oldest prediction
    always @(posedge i_clk) begin : watch
        t_assoc due;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (assoc_due_q.size() == 0) begin
                $error("result word with nothing pending: match_id %h matched %b",
                       o_match_id, o_matched);
                err_cnt++;
            end else begin
                due = assoc_due_q.pop_front();
                queries_checked++;
                if (o_match_id !== due.id) begin
                    $error("match_id: expected %h, actual %h", due.id, o_match_id);
                    err_cnt++;
                end
                if (o_matched !== due.matched) begin
                    $error("matched: expected %b, actual %b", due.matched, o_matched);
                    err_cnt++;
                end
            end
        end
    end

    task automatic queue_word(input logic [FUNC_W-1:0] f, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input logic [ID_W-1:0] id);
        t_word nw;
        nw     = '{kind: WORD_ITEM, func: f, x: x, y: y, ident: id, gate: '0};
        word_q = {word_q, nw};
    endtask

    task automatic queue_gate(input logic [GATE_W-1:0] g);
        t_word nw;
        nw     = '{kind: WORD_GATE, func: FUNC_UNUSED, x: '0, y: '0, ident: '0, gate: g};
        word_q = {word_q, nw};
    endtask

    // coordinate scattered around base by up to +/- spread, wrapping at 24 bits
    function automatic logic signed [COORD_W-1:0] jitter(input logic signed [COORD_W-1:0] base,
                                                         input int unsigned spread);
        int off;
        off = int'($urandom_range(0, 2 * spread)) - int'(spread);
        return COORD_W'(int'(base) + off);
    endfunction

    // stimulus, end of run check
    initial begin : stim
        int                        made;
        int                        n_app;
        int                        n_qry;
        int                        k;
        int unsigned               spread;
        logic [GATE_W-1:0]         gate_now;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic signed [COORD_W-1:0] lm_x[$];
        logic signed [COORD_W-1:0] lm_y[$];

        // directed: empty table, unused code, gate edge, ties, extremes
        queue_word(FUNC_QUERY, 0, 0, 16'h1234);
        queue_word(FUNC_UNUSED, -1, -1, 16'hFFFF);
        queue_word(FUNC_CLEAR, 0, 0, 0);
        queue_word(FUNC_APPEND, 12800, 0, 16'h0001);
        queue_word(FUNC_APPEND, 0, 12799, 16'hFFFF);
        queue_word(FUNC_QUERY, 0, 0, 16'h00AA);
        queue_word(FUNC_CLEAR, 0, 0, 0);
        queue_word(FUNC_APPEND, 12800, 0, 16'h0001);
        queue_word(FUNC_QUERY, 0, 0, 16'h00BB);   // exactly on the gate: no match
        queue_word(FUNC_CLEAR, 0, 0, 0);
        queue_word(FUNC_APPEND, 100, 0, 16'h0011);
        queue_word(FUNC_APPEND, -100, 0, 16'h0022);
        queue_word(FUNC_APPEND, 0, 100, 16'h0033);
        queue_word(FUNC_QUERY, 0, 0, 16'h5555);   // three-way tie
        queue_word(FUNC_CLEAR, 0, 0, 0);
        queue_word(FUNC_APPEND, C_MAX, C_MAX, 16'h0000);
        queue_word(FUNC_APPEND, C_MIN, C_MIN, 16'hFFFF);
        queue_word(FUNC_QUERY, C_MIN, C_MIN, 16'h7777);
        queue_word(FUNC_QUERY, C_MAX, C_MAX - 5, 16'h8888);
        queue_word(FUNC_QUERY, 0, 0, 16'h9999);
        queue_gate(GATE_MAX);
        queue_word(FUNC_QUERY, C_MAX, 0, 16'hA5A5);
        queue_word(FUNC_QUERY, C_MAX, 1, 16'h5A5A);
        queue_gate('0);
        queue_word(FUNC_QUERY, C_MIN, C_MIN, 16'hC3C3);  // zero gate, exact position: no match
        queue_word(FUNC_UNUSED, C_MAX, C_MIN, 16'h0F0F);
        queue_gate(GATE_RESET);
        queue_word(FUNC_QUERY, C_MIN, C_MIN, 16'h3C3C);
        gate_now = GATE_RESET;

        // random phases: optional gate write, clear, clustered appends, queries
        made = 0;
        while (made < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) < 4) begin
                case ($urandom_range(0, 7))
                    0:       gate_now = '0;
                    1:       gate_now = GATE_MAX;
                    2:       gate_now = GATE_RESET;
                    3:       gate_now = GATE_W'(1);
                    4:       gate_now = GATE_W'($urandom_range(2, 4095));
                    5, 6:    gate_now = GATE_W'($urandom_range(4096, 200000));
                    default: gate_now = GATE_W'($urandom());
                endcase
                queue_gate(gate_now);
            end
            spread = (gate_now == '0) ? 64 : int'(gate_now);
            if (spread > 4194304)
                spread = 4194304;
            // most phases start from an empty table; some pile onto the old one
            if ($urandom_range(0, 9) != 0) begin
                queue_word(FUNC_CLEAR, COORD_W'($urandom()), COORD_W'($urandom()),
                           ID_W'($urandom()));
                lm_x.delete();
                lm_y.delete();
                made++;
                if ($urandom_range(0, 9) == 0) begin
                    queue_word(FUNC_QUERY, COORD_W'($urandom()), COORD_W'($urandom()),
                               ID_W'($urandom()));
                    made++;
                end
            end
            n_app = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                  : $urandom_range(60, 70);
            cx = COORD_W'($urandom());
            cy = COORD_W'($urandom());
            for (int i = 0; i < n_app; i++) begin
                if (lm_x.size() > 0 && $urandom_range(0, 9) == 0) begin
                    k  = $urandom_range(0, lm_x.size() - 1);   // duplicate position
                    qx = lm_x[k];
                    qy = lm_y[k];
                end else begin
                    qx = jitter(cx, spread);
                    qy = jitter(cy, spread);
                end
                lm_x = {lm_x, qx};
                lm_y = {lm_y, qy};
                queue_word(FUNC_APPEND, qx, qy, ID_W'($urandom()));
                made++;
                if ($urandom_range(0, 99) < 6)
                    queue_word(FUNC_UNUSED, COORD_W'($urandom()), COORD_W'($urandom()),
                               ID_W'($urandom()));
            end
            n_qry = $urandom_range(2, 6);
            for (int i = 0; i < n_qry; i++) begin
                k = $urandom_range(0, 9);
                if (lm_x.size() == 0 || k < 2) begin
                    qx = COORD_W'($urandom());
                    qy = COORD_W'($urandom());
                end else begin
                    qx = lm_x[$urandom_range(0, lm_x.size() - 1)];
                    qy = lm_y[$urandom_range(0, lm_y.size() - 1)];
                    if (k > 2) begin
                        qx = jitter(qx, spread);
                        qy = jitter(qy, spread);
                    end
                end
                queue_word(FUNC_QUERY, qx, qy, ID_W'($urandom()));
                made++;
                if ($urandom_range(0, 99) < 6)
                    queue_word(FUNC_UNUSED, COORD_W'($urandom()), COORD_W'($urandom()),
                               ID_W'($urandom()));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0 || assoc_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (assoc_due_q.size() != 0) begin
            $error("%0d query results never arrived", assoc_due_q.size());
            err_cnt++;
        end

        $display("run covered %0d words, %0d queries checked (%0d predicted hits)",
                 words_taken, queries_checked, hits_predicted);
        $display("%0d appends dropped on a full table, %0d gate radius writes",
                 appends_dropped, gates_written);
        if (err_cnt == 0)
            $display("tb_nearest_landmark_association_core passed");
        else
            $display("tb_nearest_landmark_association_core failed");
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_nearest_landmark_association_core failed");
        $finish;
    end

endmodule
